FILE: hdl/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
// All checks are sampled on the rising edge of clk and are held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/cla_pkg.sv
`timescale 1ns / 1ps

package cla_pkg;

    // Default number of bytes that a line may hold.
    localparam int LINE_LENGTH_DEF = 64;

    // Character codes that steer the line editing.
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_DELETE    = 8'h7F;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CASE_BIT     = 8'h20;

    // Fold an upper case letter to lower case; other bytes pass unchanged.
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[CH_UPPER_A:CH_UPPER_Z]})
        begin
            r = c | CASE_BIT;
        end
        return r;
    endfunction

endpackage

FILE: hdl/command_line_assembler.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// input     in_valid / in_ready    rx_byte[7:0]
// output    out_valid / out_ready  line_byte[7:0], line_end
//
// An ordinary byte writes the line store RAM unless the line is full; backspace and delete
// only lower the fill count. A newline that completes a line blocks input after it is
// taken: the RAM read port gives one byte per cycle while out_ready does not stall the
// output, each byte passes through the output register, and the block returns to idle.
// Reset clears the fill count and the control state; the RAM needs no clearing pass.
// A stalled output holds its byte while the next byte waits in the RAM read register.
`include "assert_macros.svh"

module command_line_assembler
    import cla_pkg::*;
#(
    parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] line_byte,
    output logic       line_end
);

    localparam int AW = $clog2(LINE_LENGTH);
    localparam int CW = $clog2(LINE_LENGTH + 1);
    localparam logic [CW-1:0] LINE_MAX = CW'(LINE_LENGTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_PLAY = 1'b1;

    logic          state_reg, state_next;
    logic [CW-1:0] fill_count_reg, fill_count_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] rd_ptr_reg, rd_ptr_next;
    logic          pend_reg, pend_next;
    logic          pend_end_reg, pend_end_next;
    logic          out_valid_reg, out_valid_next;
    logic          out_end_reg, out_end_next;
    logic [7:0]    out_byte_reg, out_byte_next;

    logic       accept;
    logic       full;
    logic       is_erase;
    logic       is_newline;
    logic       wr_en;
    logic       rd_en;
    logic       pend_move;
    logic [7:0] rd_data;
    logic       in_play;
    logic       drained;
    logic       line_done;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign full      = (fill_count_reg >= LINE_MAX);
    assign is_erase  = (rx_byte == CH_BACKSPACE) || (rx_byte == CH_DELETE);
    assign is_newline = (rx_byte == CH_NEWLINE);
    assign wr_en     = accept && !full && !is_erase;

    // Status terms used by the checks at the end.
    assign in_play   = (state_reg == ST_PLAY);
    assign drained   = !pend_reg && (rd_ptr_reg == len_reg);
    assign line_done = accept && !full && is_newline;

    // The pending RAM byte moves to the output register when that register frees up.
    assign pend_move = pend_reg && (!out_valid_reg || out_ready);
    assign rd_en     = (state_reg == ST_PLAY) && (rd_ptr_reg != len_reg)
                       && (!pend_reg || pend_move);

    cla_ram #(
        .WIDTH(8),
        .DEPTH(LINE_LENGTH)
    ) u_line_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(fill_count_reg[AW-1:0]),
        .wr_data(fold_case(rx_byte)),
        .rd_en  (rd_en),
        .rd_addr(rd_ptr_reg[AW-1:0]),
        .rd_data(rd_data)
    );

    // Line editing and playout control.
    always_comb
    begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        len_next        = len_reg;
        rd_ptr_next     = rd_ptr_reg;
        pend_next       = pend_reg;
        pend_end_next   = pend_end_reg;

        if (accept)
        begin
            if (full)
            begin
                if (is_newline)
                begin
                    fill_count_next = '0;
                end
            end
            else if (is_erase)
            begin
                if (fill_count_reg != '0)
                begin
                    fill_count_next = fill_count_reg - CW'(1);
                end
            end
            else if (is_newline)
            begin
                fill_count_next = '0;
                len_next        = fill_count_reg + CW'(1);
                rd_ptr_next     = '0;
                state_next      = ST_PLAY;
            end
            else
            begin
                fill_count_next = fill_count_reg + CW'(1);
            end
        end

        if (rd_en)
        begin
            rd_ptr_next   = rd_ptr_reg + CW'(1);
            pend_next     = 1'b1;
            pend_end_next = (CW'(rd_ptr_reg + CW'(1)) == len_reg);
        end
        else if (pend_move)
        begin
            pend_next = 1'b0;
        end

        if ((state_reg == ST_PLAY) && (rd_ptr_reg == len_reg) && !pend_reg)
        begin
            state_next = ST_IDLE;
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_end_next   = out_end_reg;
        out_byte_next  = out_byte_reg;
        if (pend_move)
        begin
            out_valid_next = 1'b1;
            out_end_next   = pend_end_reg;
            out_byte_next  = rd_data;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_count_reg <= '0;
            len_reg        <= '0;
            rd_ptr_reg     <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            len_reg        <= len_next;
            rd_ptr_reg     <= rd_ptr_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_end_reg <= pend_end_next;
        out_end_reg  <= out_end_next;
        out_byte_reg <= out_byte_next;
    end

    assign out_valid = out_valid_reg;
    assign line_byte = out_byte_reg;
    assign line_end  = out_end_reg;

    // Checks on the fill count and the playout sequencing.
    `ASSERT_SAME(a_fill_bound, 1'b1, fill_count_reg <= LINE_MAX, "fill count beyond line length")
    `ASSERT_SAME(a_idle_drained, in_ready, drained, "input open during playout")
    `ASSERT_SAME(a_ptr_bound, in_play, rd_ptr_reg <= len_reg, "read pointer past line")
    `ASSERT_NEXT(a_newline_plays, line_done, in_play && (fill_count_reg == '0), "no playout")

endmodule

FILE: hdl/cla_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module cla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while rd_en is low.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cla_pkg::*;

    localparam int LINE_LEN = LINE_LENGTH_DEF;
    localparam int DIRECTED_ITEMS = 21;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES = 20;

    // One byte of a played-out line as the output channel carries it.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } line_item_t;

    // Tracks the line being edited and holds the bytes that are due on the output.
    class line_scoreboard;
        logic [7:0] line_buf [LINE_LEN];
        int unsigned fill;
        line_item_t due_q [$];
        int errors;

        function new();
            fill = 0;
            errors = 0;
        endfunction

        // Apply one accepted input byte to the line and queue any finished line.
        function void note_byte(input logic [7:0] c);
            logic [7:0] folded;
            line_item_t item;
            folded = c;
            if (fill >= LINE_LEN)
            begin
                // A full line swallows everything until a newline drops it.
                if (c == CH_NEWLINE)
                begin
                    fill = 0;
                end
                return;
            end
            if (c == CH_BACKSPACE || c == CH_DELETE)
            begin
                if (fill > 0)
                begin
                    fill--;
                end
                return;
            end
            if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            begin
                folded = c | CASE_BIT;
            end
            line_buf[fill] = folded;
            fill++;
            if (c == CH_NEWLINE)
            begin
                for (int i = 0; i < fill; i++)
                begin
                    item.data = line_buf[i];
                    item.last = (i == fill - 1);
                    due_q.push_back(item);
                end
                fill = 0;
            end
        endfunction

        // Compare one accepted output item with the oldest byte that is due.
        function void check_byte(input logic [7:0] data, input logic last);
            line_item_t want;
            if (due_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("unexpected item: byte %02h end %0b", data, last);
                end
                return;
            end
            want = due_q.pop_front();
            if (want.data !== data || want.last !== last)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: expected byte %02h end %0b, got byte %02h end %0b",
                             want.data, want.last, data, last);
                end
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] line_byte;
    logic       line_end;

    line_scoreboard sb = new();
    int items_sent;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;

    command_line_assembler #(
        .LINE_LENGTH(LINE_LEN)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .line_byte(line_byte),
        .line_end (line_end)
    );

    // Free-running clock with a 2 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Hard stop in case the block hangs.
    initial
    begin
        #400000;
        $display("command_line_assembler test failed");
        $finish;
    end

    // Receiver: pick out_ready at each falling edge, check items at the rising edge.
    initial
    begin
        out_ready = 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                sb.check_byte(line_byte, line_end);
            end
        end
    end

    // Offer one byte, idling first at random, and wait until it is accepted.
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_byte(b);
        items_sent++;
    endtask

    // Random character other than newline, optionally never an editing key.
    function automatic logic [7:0] rand_char(input bit no_edit);
        logic [7:0] c;
        do
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: c = 8'($urandom_range(8'h20, 8'h7E));
                6, 7:             c = 8'($urandom_range(CH_UPPER_A, CH_UPPER_Z));
                default:          c = 8'($urandom_range(0, 255));
            endcase
        end
        while (c == CH_NEWLINE || (no_edit && (c == CH_BACKSPACE || c == CH_DELETE)));
        return c;
    endfunction

    // A line of n characters with occasional edits unless no_edit is set, closed by a newline.
    task automatic send_line(input int n, input bit no_edit);
        for (int i = 0; i < n; i++)
        begin
            if (!no_edit && $urandom_range(0, 9) == 0)
            begin
                send_byte($urandom_range(0, 1) ? CH_BACKSPACE : CH_DELETE);
            end
            send_byte(rand_char(no_edit));
        end
        send_byte(CH_NEWLINE);
    endtask

    // Fill the line to the limit, keep typing into it, then drop it with a newline.
    task automatic send_full_line(input int extra);
        for (int i = 0; i < LINE_LEN; i++)
        begin
            send_byte(rand_char(1'b1));
        end
        for (int i = 0; i < extra; i++)
        begin
            send_byte(rand_char(1'b0));
        end
        send_byte(CH_NEWLINE);
    endtask

    // One random sequence: mostly well-formed lines, some overflows and noise.
    task automatic run_sequence();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 4)
        begin
            send_full_line($urandom_range(0, 8));
        end
        else if (pick < 7)
        begin
            send_line(LINE_LEN - 1, 1'b1);
        end
        else if (pick < 87)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            send_line(n, 1'b0);
        end
        else
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
            begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Stop offering and wait until every due byte has come out.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Main sequence: reset, directed bytes, then four phases of random traffic.
    initial
    begin
        logic [7:0] directed [DIRECTED_ITEMS];
        directed = '{CH_BACKSPACE, CH_DELETE, CH_NEWLINE,
                     8'h41, 8'h5A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h00, 8'hFF, 8'h61,
                     CH_BACKSPACE, CH_DELETE, CH_NEWLINE,
                     8'h51, CH_DELETE, CH_BACKSPACE, CH_BACKSPACE, 8'h78, CH_NEWLINE};
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = 8'h00;
        items_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            send_byte(directed[i]);
        end
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 72;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 72;
                    hold_left = LONG_HOLD_CYCLES;
                end
                default:
                begin
                    send_idle_pct = 6;
                    recv_stall_pct = 6;
                end
            endcase
            // Make sure the longest line and an overflowed line both occur.
            if (phase == 0)
            begin
                send_line(LINE_LEN - 1, 1'b1);
            end
            if (phase == 1)
            begin
                send_full_line(5);
            end
            while (items_sent < DIRECTED_ITEMS + (phase + 1) * ITEMS_PER_PHASE)
            begin
                run_sequence();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("command_line_assembler test passed");
        end
        else
        begin
            $display("command_line_assembler test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/cla_pkg.sv
hdl/cla_ram.sv
hdl/command_line_assembler.sv
tb/testbench.sv
